// ===== sv/sll_pkg.sv =====
// Shared types, codes and helpers for the shell line lexer.
// Used by sll_core, sll_queue and shell_line_lexer; depends on nothing.
package sll_pkg;

  // Default number of token slots per line
  localparam int SLOTS_DEFAULT = 64;
  // Result queue depth and the most results one request can produce
  localparam int QDEPTH = 8;
  localparam int MAX_RES = 4;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_WORD_END = 2'd1,
    KIND_OPER = 2'd2,
    KIND_LINE_DONE = 2'd3
  } kind_t;

  // Token kinds
  typedef enum logic [3:0] {
    TK_WORD = 4'd0,
    TK_PIPE = 4'd1,
    TK_OUT = 4'd2,
    TK_IN = 4'd3,
    TK_APPEND = 4'd4,
    TK_SEMI = 4'd5,
    TK_ANDAND = 4'd6,
    TK_OROR = 4'd7,
    TK_NEWLINE = 4'd8,
    TK_EOF = 4'd9
  } tok_t;

  // Line status at line done
  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_OPEN_SQ = 2'd1,
    ST_OPEN_DQ = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  // Operator waiting for its second character
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_GT = 2'd1,
    PEND_BAR = 2'd2,
    PEND_AMP = 2'd3
  } pend_t;

  // Quote mode
  typedef enum logic [1:0] {
    QM_NONE = 2'd0,
    QM_SINGLE = 2'd1,
    QM_DOUBLE = 2'd2,
    QM_UNUSED = 2'd3
  } qmode_t;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_BAR = 8'h7C;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_SQ = 8'h27;
  localparam logic [7:0] CH_DQ = 8'h22;

  // One result
  typedef struct packed {
    kind_t kind;
    logic [7:0] text_byte;
    tok_t token_kind;
    logic single_quoted;
    logic double_quoted;
    status_t status;
    logic last_of_run;
  } res_t;

  // Results produced by one request, in order
  typedef struct packed {
    logic [2:0] count;
    res_t [MAX_RES-1:0] item;
  } batch_t;

  // Build one result
  function automatic res_t mk_res(kind_t kind, logic [7:0] byte_v, tok_t tk,
                                  logic sq, logic dq, status_t st);
    res_t r;
    r.kind = kind;
    r.text_byte = byte_v;
    r.token_kind = tk;
    r.single_quoted = sq;
    r.double_quoted = dq;
    r.status = st;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Append a result to a batch
  function automatic batch_t push_res(batch_t b, res_t r);
    batch_t o;
    o = b;
    if (o.count < 3'(MAX_RES)) begin
      o.item[o.count[1:0]] = r;
      o.count = o.count + 3'd1;
    end
    return o;
  endfunction

endpackage

// ===== sv/sll_core.sv =====
// Lexer state and the single-pass token logic for one input byte.
// Depends on sll_pkg; feeds its result batch to sll_queue.
module sll_core
  import sll_pkg::*;
#(
  parameter int TOKEN_SLOTS = SLOTS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       ch_valid,
  input  logic       line_end,
  output batch_t     batch
);

  localparam int UW = $clog2(TOKEN_SLOTS + 1);
  localparam logic [UW-1:0] SLOTS = UW'(TOKEN_SLOTS);

  pend_t pend_r, pend_nxt;
  qmode_t qm_r, qm_nxt;
  logic whc_r, whc_nxt;
  logic ssq_r, ssq_nxt;
  logic sdq_r, sdq_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic failed_r, failed_nxt;

  // Token logic, in the order the byte is handled, then line end
  always_comb begin
    batch_t b;
    logic done;
    logic ok;
    status_t st;
    tok_t tk;
    b = '0;
    done = 1'b0;
    ok = 1'b1;
    st = ST_OK;
    tk = TK_WORD;
    pend_nxt = pend_r;
    qm_nxt = qm_r;
    whc_nxt = whc_r;
    ssq_nxt = ssq_r;
    sdq_nxt = sdq_r;
    used_nxt = used_r;
    failed_nxt = failed_r;

    if (ch_valid && !failed_r) begin
      // pending operator: complete a doubled one, flush a lone > or |, drop a lone &
      if (pend_nxt != PEND_NONE) begin
        if ((pend_nxt == PEND_GT && ch == CH_GT) || (pend_nxt == PEND_BAR && ch == CH_BAR) ||
            (pend_nxt == PEND_AMP && ch == CH_AMP)) begin
          tk = (pend_nxt == PEND_GT) ? TK_APPEND : (pend_nxt == PEND_BAR) ? TK_OROR : TK_ANDAND;
          if (used_nxt < SLOTS) begin
            used_nxt = used_nxt + 1'b1;
            b = push_res(b, mk_res(KIND_OPER, 8'h00, tk, 1'b0, 1'b0, ST_OK));
          end
          done = 1'b1;
        end else if (pend_nxt == PEND_GT || pend_nxt == PEND_BAR) begin
          tk = (pend_nxt == PEND_GT) ? TK_OUT : TK_PIPE;
          if (used_nxt < SLOTS) begin
            used_nxt = used_nxt + 1'b1;
            b = push_res(b, mk_res(KIND_OPER, 8'h00, tk, 1'b0, 1'b0, ST_OK));
          end
        end
        pend_nxt = PEND_NONE;
      end

      if (!done) begin
        if (qm_nxt == QM_SINGLE || qm_nxt == QM_DOUBLE) begin
          // quoted: everything literal up to the closing quote
          if ((qm_nxt == QM_SINGLE && ch == CH_SQ) || (qm_nxt == QM_DOUBLE && ch == CH_DQ)) begin
            qm_nxt = QM_NONE;
          end else begin
            whc_nxt = 1'b1;
            b = push_res(b, mk_res(KIND_CHAR, ch, TK_WORD, 1'b0, 1'b0, ST_OK));
          end
        end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_BAR ||
                     ch == CH_GT || ch == CH_LT || ch == CH_SEMI || ch == CH_AMP ||
                     ch == CH_NL) begin
          // separator or operator: close the word first
          if (whc_nxt) begin
            if (used_nxt < SLOTS) begin
              used_nxt = used_nxt + 1'b1;
              b = push_res(b, mk_res(KIND_WORD_END, 8'h00, TK_WORD, ssq_nxt, sdq_nxt, ST_OK));
            end else begin
              failed_nxt = 1'b1;
              ok = 1'b0;
            end
          end
          whc_nxt = 1'b0;
          ssq_nxt = 1'b0;
          sdq_nxt = 1'b0;
          if (ok) begin
            if (ch == CH_GT) begin
              pend_nxt = PEND_GT;
            end else if (ch == CH_BAR) begin
              pend_nxt = PEND_BAR;
            end else if (ch == CH_AMP) begin
              pend_nxt = PEND_AMP;
            end else if (ch == CH_LT || ch == CH_SEMI || ch == CH_NL) begin
              tk = (ch == CH_LT) ? TK_IN : (ch == CH_SEMI) ? TK_SEMI : TK_NEWLINE;
              if (used_nxt < SLOTS) begin
                used_nxt = used_nxt + 1'b1;
                b = push_res(b, mk_res(KIND_OPER, 8'h00, tk, 1'b0, 1'b0, ST_OK));
              end
            end
          end
        end else if (ch == CH_SQ) begin
          qm_nxt = QM_SINGLE;
          ssq_nxt = 1'b1;
        end else if (ch == CH_DQ) begin
          qm_nxt = QM_DOUBLE;
          sdq_nxt = 1'b1;
        end else begin
          whc_nxt = 1'b1;
          b = push_res(b, mk_res(KIND_CHAR, ch, TK_WORD, 1'b0, 1'b0, ST_OK));
        end
      end
    end

    if (line_end) begin
      tk = TK_WORD;
      if (failed_nxt) begin
        st = ST_EXHAUSTED;
      end else if (qm_nxt == QM_SINGLE) begin
        st = ST_OPEN_SQ;
      end else if (qm_nxt == QM_DOUBLE) begin
        st = ST_OPEN_DQ;
      end else begin
        // flush a lone > or |, then close the word, then the eof token
        if ((pend_nxt == PEND_GT || pend_nxt == PEND_BAR) && used_nxt < SLOTS) begin
          used_nxt = used_nxt + 1'b1;
          b = push_res(b, mk_res(KIND_OPER, 8'h00, (pend_nxt == PEND_GT) ? TK_OUT : TK_PIPE,
                                 1'b0, 1'b0, ST_OK));
        end
        ok = 1'b1;
        if (whc_nxt) begin
          if (used_nxt < SLOTS) begin
            used_nxt = used_nxt + 1'b1;
            b = push_res(b, mk_res(KIND_WORD_END, 8'h00, TK_WORD, ssq_nxt, sdq_nxt, ST_OK));
          end else begin
            ok = 1'b0;
          end
        end
        if (!ok || used_nxt >= SLOTS) begin
          st = ST_EXHAUSTED;
        end else begin
          tk = TK_EOF;
        end
      end
      b = push_res(b, mk_res(KIND_LINE_DONE, 8'h00, tk, 1'b0, 1'b0, st));
      pend_nxt = PEND_NONE;
      qm_nxt = QM_NONE;
      whc_nxt = 1'b0;
      ssq_nxt = 1'b0;
      sdq_nxt = 1'b0;
      used_nxt = '0;
      failed_nxt = 1'b0;
    end

    // mark the last result of this request
    if (b.count != 3'd0) begin
      b.item[2'(b.count - 3'd1)].last_of_run = 1'b1;
    end
    if (!accept) begin
      b.count = 3'd0;
    end
    batch = b;
  end

  // Lexer state, advanced per accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_NONE;
      qm_r <= QM_NONE;
      whc_r <= 1'b0;
      ssq_r <= 1'b0;
      sdq_r <= 1'b0;
      used_r <= '0;
      failed_r <= 1'b0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      qm_r <= qm_nxt;
      whc_r <= whc_nxt;
      ssq_r <= ssq_nxt;
      sdq_r <= sdq_nxt;
      used_r <= used_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// ===== sv/sll_queue.sv =====
// Result queue: takes up to four results a cycle, gives one a cycle while out_ready is high.
// Depends on sll_pkg; written by sll_core, read by the output channel.
module sll_queue
  import sll_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  batch_t batch,
  output logic   room,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   out_res
);

  localparam int QAW = $clog2(QDEPTH);

  res_t mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0] cnt_r, cnt_nxt;
  logic pop;

  assign out_valid = (cnt_r != '0);
  assign out_res = mem[rd_ptr_r];
  assign pop = out_valid && out_ready;
  // space for a full batch
  assign room = (cnt_r <= (QAW+1)'(QDEPTH - MAX_RES));
  assign cnt_nxt = cnt_r + (QAW+1)'(batch.count) - (QAW+1)'(pop);

  // Storage writes
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (3'(i) < batch.count) begin
        mem[wr_ptr_r + QAW'(i)] <= batch.item[i];
      end
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QAW'(batch.count);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/shell_line_lexer.sv =====
// Top level of the streaming shell line lexer: stream ports, core and result queue.
// Depends on sll_pkg, sll_core and sll_queue.
//
//   channel | direction | data                    | user       | last
//   in_     | slave     | ch                      | ch_valid   | line_end
//   out_    | master    | text_byte .. status     | kind       | last_of_run
//
// One input byte is taken per cycle; its up to four results are built in the
// same cycle and written into an eight-entry result queue read at one per cycle.
// in_tready drops while the queue has fewer than four free entries, so the rate
// is set by the output side: one result per cycle.
// Reset (rst_n low, synchronous) clears the lexer state and empties the queue.
// A stall on out_tready only fills the queue; no result is lost or repeated.
module shell_line_lexer
  import sll_pkg::*;
#(
  parameter int TOKEN_SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] ch_valid
  input  logic        in_tlast,   // line_end
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] text_byte, [11:8] token_kind, [12] single_quoted, [13] double_quoted,
  // [15:14] status
  output logic [15:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last_of_run
);

  logic accept;
  batch_t batch;
  res_t res;

  assign accept = in_tvalid && in_tready;

  sll_core #(
    .TOKEN_SLOTS(TOKEN_SLOTS)
  ) u_core (
    .clk(clk),
    .rst_n(rst_n),
    .accept(accept),
    .ch(in_tdata),
    .ch_valid(in_tuser),
    .line_end(in_tlast),
    .batch(batch)
  );

  sll_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .batch(batch),
    .room(in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res(res)
  );

  // Result packing
  assign out_tdata = {res.status, res.double_quoted, res.single_quoted, res.token_kind,
                      res.text_byte};
  assign out_tuser = res.kind;
  assign out_tlast = res.last_of_run;

  // A line end always leaves at least one result queued
  a_line_done_queued: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> out_tvalid)
    else $error("line end request left the result queue empty");

  // Results enter the queue only for an accepted request
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> batch.count == 3'd0)
    else $error("results produced without an accepted request");

  // A line end request always yields a line done result
  a_line_done_made: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |-> batch.count != 3'd0 &&
      batch.item[2'(batch.count - 3'd1)].kind == KIND_LINE_DONE)
    else $error("line end without a line done result");

endmodule
